// File: hw/rtl/wsfe_pkg.sv
package wsfe_pkg;

  // Frame geometry and queue sizing.
  localparam int FrameBytes = 9;
  localparam int FrameBits  = FrameBytes * 8;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int CfgAddrW   = 4;
  localparam int CfgDataW   = 32;

  // Type bytes for the two frame kinds.
  localparam logic [7:0] TypeLong0  = 8'h1A;
  localparam logic [7:0] TypeLong1  = 8'h2D;
  localparam logic [7:0] TypeShort0 = 8'hEA;
  localparam logic [7:0] TypeShort1 = 8'h4C;

  // Field codes and arithmetic constants.
  localparam logic [7:0]         BattLowCode = 8'h0C;
  localparam logic [7:0]         SignNegCode = 8'h08;
  localparam logic [7:0]         CsumBias    = 8'h0A;
  localparam logic signed [10:0] TempMax     = 11'sd999;
  localparam logic signed [10:0] TempMin     = -11'sd999;
  localparam logic [6:0]         HumMax      = 7'd99;
  localparam logic [7:0]         Recip10     = 8'd205;
  localparam int                 Recip10Sh   = 11;

  // Bit counts of each section of one copy.
  localparam logic [6:0] PreBits       = 7'd16;
  localparam logic [6:0] DataBitsLong  = 7'd72;
  localparam logic [6:0] DataBitsShort = 7'd64;
  localparam logic [6:0] PostBitsLong  = 7'd8;
  localparam logic [6:0] PostBitsShort = 7'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegChannel = 2'd0;
  localparam logic [1:0] RegIdent   = 2'd1;
  localparam logic [1:0] RegHumMode = 2'd2;

  // Sequencer phases of the back end.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_DATA,
    PH_POST,
    PH_PAUSE
  } phase_e;

  // Configuration registers as seen by the front end.
  typedef struct packed {
    logic [7:0] channel_code;
    logic [7:0] sensor_ident;
    logic       humidity_mode;
  } cfg_t;

  // One classified item in the queue between front and back.
  typedef struct packed {
    logic                 is_load;
    logic                 long_frame;
    logic [FrameBits-1:0] frame;
  } op_t;

endpackage

// File: hw/rtl/wsfe_if.sv
// Input channel: one measurement or tick item.
interface wsfe_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [10:0] temperature_tenths;
  logic        [6:0]  humidity_percent;
  logic               battery_ok;

  modport source (output valid, action, temperature_tenths, humidity_percent, battery_ok,
                  input ready);
  modport sink   (input valid, action, temperature_tenths, humidity_percent, battery_ok,
                  output ready);
endinterface

// Output channel: one result item per input item.
interface wsfe_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;

  modport source (output valid, line_level, busy_res, accepted, input ready);
  modport sink   (input valid, line_level, busy_res, accepted, output ready);
endinterface

// File: hw/rtl/wsfe_regs.sv
module wsfe_regs
  import wsfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register write decode; writes beyond the list fall through.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegChannel: cfg_d.channel_code  = pwdata[7:0];
        RegIdent:   cfg_d.sensor_ident  = pwdata[7:0];
        RegHumMode: cfg_d.humidity_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_code  <= 8'd16;
      cfg_q.sensor_ident  <= 8'd0;
      cfg_q.humidity_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      RegChannel: prdata = {24'd0, cfg_q.channel_code};
      RegIdent:   prdata = {24'd0, cfg_q.sensor_ident};
      RegHumMode: prdata = {31'd0, cfg_q.humidity_mode};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/wsfe_front.sv
module wsfe_front
  import wsfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  wsfe_in_if.sink      in_s,
  input  cfg_t         cfg_i,
  output op_t          op_o,
  output logic         op_valid_o,
  input  logic         op_ready_i
);

  // First stage: clamping and the first digit split.
  logic       s1_valid_q;
  logic       s1_load_q, s1_long_q, s1_neg_q, s1_batt_q;
  logic [9:0] s1_mag_q;
  logic [6:0] s1_whole_q;
  logic [6:0] s1_hum_q;
  logic [3:0] s1_hum_tens_q;
  logic [7:0] s1_chan_q, s1_ident_q;

  logic               take;
  logic signed [10:0] temp_c;
  logic        [9:0]  mag;
  logic        [17:0] mag_prod;
  logic        [6:0]  hum_c;
  logic        [14:0] hum_prod;

  assign in_s.ready = !s1_valid_q || op_ready_i;
  assign take       = in_s.valid && in_s.ready;

  always_comb begin
    if (in_s.temperature_tenths > TempMax) begin
      temp_c = TempMax;
    end else if (in_s.temperature_tenths < TempMin) begin
      temp_c = TempMin;
    end else begin
      temp_c = in_s.temperature_tenths;
    end
    mag      = temp_c[10] ? 10'(-temp_c) : 10'(temp_c);
    mag_prod = 18'(mag) * 18'(Recip10);
    hum_c    = (in_s.humidity_percent > HumMax) ? HumMax : in_s.humidity_percent;
    hum_prod = 15'(hum_c) * 15'(Recip10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_load_q     <= in_s.action;
      s1_long_q     <= cfg_i.humidity_mode;
      s1_neg_q      <= in_s.temperature_tenths[10];
      s1_batt_q     <= in_s.battery_ok;
      s1_mag_q      <= mag;
      s1_whole_q    <= mag_prod[Recip10Sh+6:Recip10Sh];
      s1_hum_q      <= hum_c;
      s1_hum_tens_q <= hum_prod[Recip10Sh+3:Recip10Sh];
      s1_chan_q     <= cfg_i.channel_code;
      s1_ident_q    <= cfg_i.sensor_ident;
    end
  end

  // Second stage: remaining digits, frame bytes and checksum.
  function automatic logic [7:0] nib_pair(input logic [7:0] b);
    return 8'(b[7:4]) + 8'(b[3:0]);
  endfunction

  logic [14:0] whole_prod;
  logic [3:0]  temp_tens, temp_units, temp_tenth, hum_units;
  logic [7:0]  b0, b1, b4, b5, b6, b7, b8;
  logic [7:0]  head_sum, csum;

  always_comb begin
    whole_prod = 15'(s1_whole_q) * 15'(Recip10);
    temp_tens  = whole_prod[Recip10Sh+3:Recip10Sh];
    temp_units = 4'(s1_whole_q - 7'(7'(temp_tens) * 7'd10));
    temp_tenth = 4'(s1_mag_q - 10'(10'(s1_whole_q) * 10'd10));
    hum_units  = 4'(s1_hum_q - 7'(7'(s1_hum_tens_q) * 7'd10));

    b0 = s1_long_q ? TypeLong0 : TypeShort0;
    b1 = s1_long_q ? TypeLong1 : TypeShort1;
    b4 = (s1_batt_q ? 8'h00 : BattLowCode) | {temp_tenth, 4'h0};
    b5 = {temp_tens, temp_units};
    b6 = s1_neg_q ? SignNegCode : 8'h00;
    head_sum = nib_pair(b0) + nib_pair(b1) + nib_pair(s1_chan_q) + nib_pair(s1_ident_q)
             + nib_pair(b4) + nib_pair(b5);

    if (s1_long_q) begin
      b6   = b6 | {hum_units, 4'h0};
      b7   = 8'(s1_hum_tens_q);
      csum = head_sum + nib_pair(b6) + nib_pair(b7) - CsumBias;
      b8   = csum;
    end else begin
      csum = head_sum + 8'(b6[3:0]) - CsumBias;
      b6   = b6 | {csum[3:0], 4'h0};
      b7   = 8'(csum[7:4]);
      b8   = 8'h00;
    end

    op_o.is_load    = s1_load_q;
    op_o.long_frame = s1_long_q;
    op_o.frame      = {b8, b7, b6, b5, b4, s1_ident_q, s1_chan_q, b1, b0};
  end

  assign op_valid_o = s1_valid_q;

endmodule

// File: hw/rtl/wsfe_queue.sv
module wsfe_queue
  import wsfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  op_t  push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output op_t  pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  op_t                  entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Pointer wrap at the queue depth.
  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] p);
    return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: hw/rtl/wsfe_back.sv
module wsfe_back
  import wsfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  op_t       op_i,
  input  logic      op_valid_i,
  output logic      op_ready_o,
  wsfe_out_if.source out_s
);

  phase_e               phase_q, phase_d;
  logic [6:0]           bit_cnt_q, bit_cnt_d;
  logic [1:0]           slot_q, slot_d;
  logic [3:0]           pause_q, pause_d;
  logic                 copy_q, copy_d;
  logic                 pin_q, pin_d;
  logic                 long_q, long_d;
  logic [FrameBits-1:0] frame_q;
  logic                 out_valid_q;
  logic                 level_q, busy_q, acc_q;

  logic       pop, load_frame;
  logic       level, acc, bit_v;
  logic [6:0] bit_next, limit;

  assign op_ready_o = !out_valid_q || out_s.ready;
  assign pop        = op_valid_i && op_ready_o;

  // Step of the slot sequencer for one item.
  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    slot_d     = slot_q;
    pause_d    = pause_q;
    copy_d     = copy_q;
    pin_d      = pin_q;
    long_d     = long_q;
    load_frame = 1'b0;
    acc        = 1'b0;
    level      = pin_q;
    bit_v      = 1'b0;
    bit_next   = bit_cnt_q + 1'b1;
    limit      = PreBits;

    unique case (phase_q)
      PH_PRE:  limit = PreBits;
      PH_DATA: limit = long_q ? DataBitsLong : DataBitsShort;
      default: limit = long_q ? PostBitsLong : PostBitsShort;
    endcase

    if (op_i.is_load) begin
      // A load is taken only while idle; otherwise it is dropped.
      if (phase_q == PH_IDLE) begin
        load_frame = 1'b1;
        long_d     = op_i.long_frame;
        phase_d    = PH_PRE;
        bit_cnt_d  = '0;
        slot_d     = '0;
        pause_d    = '0;
        copy_d     = 1'b0;
        acc        = 1'b1;
      end
    end else if (phase_q == PH_IDLE) begin
      level = 1'b0;
    end else if (phase_q == PH_PAUSE) begin
      level   = 1'b0;
      pin_d   = 1'b0;
      pause_d = pause_q + 1'b1;
      if (pause_q == 4'hF) begin
        copy_d    = 1'b1;
        phase_d   = PH_PRE;
        bit_cnt_d = '0;
        slot_d    = '0;
      end
    end else begin
      unique case (phase_q)
        PH_PRE:  bit_v = 1'b1;
        PH_DATA: bit_v = frame_q[bit_cnt_q];
        default: bit_v = 1'b0;
      endcase
      // A one is low-high-high-low, a zero is high-low-low-high.
      level  = bit_v ^ ((slot_q == 2'd0) || (slot_q == 2'd3));
      pin_d  = level;
      slot_d = slot_q + 1'b1;
      if (slot_q == 2'd3) begin
        bit_cnt_d = bit_next;
        if (bit_next >= limit) begin
          bit_cnt_d = '0;
          unique case (phase_q)
            PH_PRE:  phase_d = PH_DATA;
            PH_DATA: phase_d = PH_POST;
            default: begin
              if (!copy_q) begin
                phase_d = PH_PAUSE;
                pause_d = '0;
              end else begin
                phase_d = PH_IDLE;
                copy_d  = 1'b0;
                pin_d   = 1'b0;
              end
            end
          endcase
        end
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      slot_q    <= '0;
      pause_q   <= '0;
      copy_q    <= 1'b0;
      pin_q     <= 1'b0;
      long_q    <= 1'b0;
    end else if (pop) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      slot_q    <= slot_d;
      pause_q   <= pause_d;
      copy_q    <= copy_d;
      pin_q     <= pin_d;
      long_q    <= long_d;
    end
  end

  // Frame store, written only on a taken load.
  always_ff @(posedge clk_i) begin
    if (pop && load_frame) frame_q <= op_i.frame;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_ready_o) begin
      out_valid_q <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      level_q <= level;
      busy_q  <= phase_d != PH_IDLE;
      acc_q   <= acc;
    end
  end

  assign out_s.valid      = out_valid_q;
  assign out_s.line_level = level_q;
  assign out_s.busy_res   = busy_q;
  assign out_s.accepted   = acc_q;

endmodule

// File: hw/rtl/weather_sensor_rf_frame_encoder.sv
// Channel    Direction  Handshake       Payload
// sensor_i   in         valid/ready     action, temperature_tenths, humidity_percent,
//                                       battery_ok
// frame_o    out        valid/ready     line_level, busy_res, accepted
// config     in/out     APB, pready=1   channel_code @0x0, sensor_ident @0x4,
//                                       humidity_mode @0x8
//
// One item per cycle sustained while the output is not stalled; a result passes
// through the front stage register, the queue and the output register.
// Reset clears all control state; the frame store holds nothing until a load.
// A two-entry queue parts the front from the back, so a stalled output only
// backs up into the front once the queue and the front stage are full.
module weather_sensor_rf_frame_encoder
  import wsfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  wsfe_in_if.sink             sensor_i,
  wsfe_out_if.source          frame_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  op_t  front_op, back_op;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  // Configuration registers.
  wsfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front end: classify items and build frames.
  wsfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (sensor_i),
    .cfg_i      (cfg),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready)
  );

  // Queue between front and back.
  wsfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_op),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_op),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // Back end: slot sequencer and output register.
  wsfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (back_op),
    .op_valid_i (back_valid),
    .op_ready_o (back_ready),
    .out_s      (frame_o)
  );

endmodule

// File: hw/rtl/wsfe_checker.sv
module wsfe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic busy_res_i,
  input logic accepted_i
);

  logic out_acc;
  logic last_busy_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Busy flag of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_busy_q <= 1'b0;
    end else if (out_acc) begin
      last_busy_q <= busy_res_i;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_level_i)
      && $stable(busy_res_i) && $stable(accepted_i))
    else $error("result changed while stalled");

  // A taken load always starts a transmission.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && accepted_i |-> busy_res_i)
    else $error("load taken without busy");

  // A load is only taken when the previous result showed idle.
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && accepted_i |-> !last_busy_q)
    else $error("load taken while busy");

  // After idle the line stays low until the next slot is driven.
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_busy_q |-> !line_level_i)
    else $error("line high while idle");

endmodule

bind weather_sensor_rf_frame_encoder wsfe_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .line_level_i (frame_o.line_level),
  .busy_res_i   (frame_o.busy_res),
  .accepted_i   (frame_o.accepted)
);

// File: dv/weather_sensor_rf_frame_encoder_test.sv
`timescale 1ns / 1ps

module weather_sensor_rf_frame_encoder_test;
  import wsfe_pkg::*;

  // Cycles without any item moving before the run is declared hung.
  localparam int QuietLimit  = 1000;
  // Cycles to let the pipeline settle once nothing more is due.
  localparam int DrainCycles = 10;
  // Ticks driven after the last load; the run ends partway through that frame.
  localparam int TailTicks   = 120;

  typedef struct packed {
    logic               action;
    logic signed [10:0] temperature_tenths;
    logic        [6:0]  humidity_percent;
    logic               battery_ok;
  } sensor_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } line_result_t;

  // Tracks the encoder state and holds the line levels still due on the output.
  class line_level_scoreboard;
    logic [7:0]   channel_code  = 8'd16;
    logic [7:0]   sensor_ident  = 8'd0;
    logic         humidity_mode = 1'b0;
    logic [7:0]   frame_store [FrameBytes];
    phase_e       phase     = PH_IDLE;
    logic [6:0]   bit_cnt   = '0;
    logic [1:0]   slot      = '0;
    logic [3:0]   pause_cnt = '0;
    logic         copy_sel  = 1'b0;
    logic         pin       = 1'b0;
    logic         long_frame = 1'b0;
    line_result_t due_q [$];
    int           errors = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        RegChannel: channel_code = value;
        RegIdent:   sensor_ident = value;
        RegHumMode: humidity_mode = value[0];
        default: ;
      endcase
    endfunction

    function bit is_busy();
      return phase != PH_IDLE;
    endfunction

    function int nibble_sum(int count);
      int s;
      s = 0;
      for (int i = 0; i < count; i++) begin
        s += frame_store[i][7:4] + frame_store[i][3:0];
      end
      return s;
    endfunction

    // Builds the frame bytes from one measurement, with saturation and BCD split.
    function void build_frame(sensor_item_t it);
      int   t;
      int   mag;
      int   whole;
      int   hum;
      int   csum;
      logic neg;
      t = $signed(it.temperature_tenths);
      neg = t < 0;
      if (t > 999) t = 999;
      if (t < -999) t = -999;
      mag = neg ? -t : t;
      whole = mag / 10;
      hum = it.humidity_percent;
      if (hum > 99) hum = 99;
      long_frame = humidity_mode;
      frame_store[0] = long_frame ? TypeLong0 : TypeShort0;
      frame_store[1] = long_frame ? TypeLong1 : TypeShort1;
      frame_store[2] = channel_code;
      frame_store[3] = sensor_ident;
      frame_store[4] = (it.battery_ok ? 8'h00 : BattLowCode) | 8'((mag % 10) << 4);
      frame_store[5] = 8'(((whole / 10) << 4) | (whole % 10));
      frame_store[6] = neg ? SignNegCode : 8'h00;
      frame_store[7] = 8'h00;
      frame_store[8] = 8'h00;
      if (long_frame) begin
        frame_store[7] = 8'(hum / 10);
        frame_store[6] |= 8'((hum % 10) << 4);
        frame_store[8] = 8'(nibble_sum(8) - CsumBias);
      end else begin
        csum = (nibble_sum(6) + frame_store[6][3:0] - CsumBias) & 8'hFF;
        frame_store[6] |= 8'((csum & 4'hF) << 4);
        frame_store[7] = 8'(csum >> 4);
      end
    endfunction

    function logic [6:0] section_bits();
      if (phase == PH_PRE) return PreBits;
      if (phase == PH_DATA) return long_frame ? DataBitsLong : DataBitsShort;
      return long_frame ? PostBitsLong : PostBitsShort;
    endfunction

    // Drives one quarter-bit slot and steps the send sequence.
    function logic next_slot_level();
      logic level;
      logic data_bit;
      int   idx;
      if (phase == PH_PAUSE) begin
        pause_cnt = pause_cnt + 4'd1;
        if (pause_cnt == 4'd0) begin
          copy_sel = 1'b1;
          phase = PH_PRE;
          bit_cnt = '0;
          slot = '0;
        end
        pin = 1'b0;
        return 1'b0;
      end
      if (phase == PH_PRE) begin
        data_bit = 1'b1;
      end else if (phase == PH_DATA) begin
        idx = (bit_cnt >> 3) % FrameBytes;
        data_bit = frame_store[idx][bit_cnt[2:0]];
      end else begin
        data_bit = 1'b0;
      end
      // A one is low-high-high-low and a zero is high-low-low-high.
      if (data_bit) level = (slot == 2'd1) || (slot == 2'd2);
      else level = (slot == 2'd0) || (slot == 2'd3);
      pin = level;
      slot = slot + 2'd1;
      if (slot == 2'd0) begin
        bit_cnt = bit_cnt + 7'd1;
        if (bit_cnt >= section_bits()) begin
          bit_cnt = '0;
          if (phase == PH_PRE) begin
            phase = PH_DATA;
          end else if (phase == PH_DATA) begin
            phase = PH_POST;
          end else if (!copy_sel) begin
            phase = PH_PAUSE;
            pause_cnt = '0;
          end else begin
            phase = PH_IDLE;
            copy_sel = 1'b0;
            pin = 1'b0;
          end
        end
      end
      return level;
    endfunction

    // Notes an accepted sensor item and queues the line result it causes.
    function void take_sensor_item(sensor_item_t it);
      line_result_t r;
      r = '0;
      if (it.action) begin
        if (phase == PH_IDLE) begin
          build_frame(it);
          phase = PH_PRE;
          bit_cnt = '0;
          slot = '0;
          pause_cnt = '0;
          copy_sel = 1'b0;
          r.accepted = 1'b1;
        end
        r.line_level = pin;
      end else if (phase == PH_IDLE) begin
        r.line_level = 1'b0;
      end else begin
        r.line_level = next_slot_level();
      end
      r.busy_res = phase != PH_IDLE;
      due_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("%0t: %s", $time, msg);
      errors++;
    endtask

    // Compares one output item with the oldest line result still due.
    task check_line_result(line_result_t got);
      line_result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected item level=%b busy=%b accepted=%b",
                         got.line_level, got.busy_res, got.accepted));
        return;
      end
      want = due_q.pop_front();
      if (got.line_level !== want.line_level)
        report($sformatf("line_level %b, want %b", got.line_level, want.line_level));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  wsfe_in_if  sensor_if ();
  wsfe_out_if frame_if ();

  line_level_scoreboard sb = new();
  bit idle_on = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  weather_sensor_rf_frame_encoder i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sensor_i (sensor_if),
    .frame_o  (frame_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      frame_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      frame_if.ready <= 1'b0;
    end else begin
      frame_if.ready <= 1'b1;
    end
  end

  // Check every output item as it is taken.
  always @(posedge clk_i) begin
    if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
      sb.check_line_result('{frame_if.line_level, frame_if.busy_res, frame_if.accepted});
    end
  end

  // Hang detection.
  always @(posedge clk_i) begin
    if ((sensor_if.valid === 1'b1 && sensor_if.ready === 1'b1) ||
        (frame_if.valid === 1'b1 && frame_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("weather_sensor_rf_frame_encoder test failed");
      $finish;
    end
  end

  function automatic sensor_item_t random_item(logic action);
    sensor_item_t it;
    it.action = action;
    it.temperature_tenths = 11'($urandom);
    it.humidity_percent = 7'($urandom);
    it.battery_ok = 1'($urandom);
    return it;
  endfunction

  // Mostly in-range temperatures, with the saturation and sign corners mixed in.
  function automatic logic signed [10:0] pick_temperature();
    int corners [10] = '{-1024, 1023, -1000, 1000, -999, 999, 0, -1, -10, 995};
    case ($urandom_range(0, 5))
      0:       return 11'(corners[$urandom_range(0, 9)]);
      1:       return 11'($urandom);
      default: return 11'(int'($urandom_range(0, 1998)) - 999);
    endcase
  endfunction

  function automatic logic [6:0] pick_humidity();
    int corners [4] = '{0, 99, 100, 127};
    case ($urandom_range(0, 3))
      0:       return 7'($urandom_range(0, 127));
      1:       return 7'(corners[$urandom_range(0, 3)]);
      default: return 7'($urandom_range(0, 99));
    endcase
  endfunction

  // Offers one item, with an optional gap first, and waits until it is taken.
  task automatic push_item(sensor_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sensor_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    sensor_if.valid              <= 1'b1;
    sensor_if.action             <= it.action;
    sensor_if.temperature_tenths <= it.temperature_tenths;
    sensor_if.humidity_percent   <= it.humidity_percent;
    sensor_if.battery_ok         <= it.battery_ok;
    do @(posedge clk_i); while (sensor_if.ready !== 1'b1);
    sb.take_sensor_item(it);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic verify_reg(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (got !== want) sb.report($sformatf("register %0d reads %h, want %h", idx, got, want));
  endtask

  task automatic apply_setup(logic [7:0] channel, logic [7:0] ident, logic mode);
    write_reg(RegChannel, channel);
    write_reg(RegIdent, ident);
    write_reg(RegHumMode, {7'd0, mode});
    verify_reg(RegChannel, {24'd0, channel});
    verify_reg(RegIdent, {24'd0, ident});
    verify_reg(RegHumMode, {31'd0, mode});
  endtask

  // Stops offering items and waits until every line result has come out.
  task automatic wait_for_drain();
    sensor_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Ticks the encoder until both copies and the pause have gone out.
  task automatic finish_frame();
    while (sb.is_busy()) begin
      // A load now and then while busy must be ignored.
      if ($urandom_range(0, 59) == 0) push_item(random_item(1'b1));
      else push_item(random_item(1'b0));
    end
  endtask

  // Drives up to two ticks, loads one random measurement and then drives a fixed number of ticks.
  task automatic send_frame(int ticks);
    sensor_item_t it;
    repeat ($urandom_range(0, 2)) push_item(random_item(1'b0));
    it = random_item(1'b1);
    it.temperature_tenths = pick_temperature();
    it.humidity_percent = pick_humidity();
    push_item(it);
    repeat (ticks) push_item(random_item(1'b0));
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sensor_if.valid = 1'b0;
    sensor_if.action = 1'b0;
    sensor_if.temperature_tenths = '0;
    sensor_if.humidity_percent = '0;
    sensor_if.battery_ok = 1'b0;
    frame_if.ready = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values of the registers.
    verify_reg(RegChannel, 32'd16);
    verify_reg(RegIdent, 32'd0);
    verify_reg(RegHumMode, 32'd0);

    // Directed: ticks while idle, an out-of-range load, then loads while busy.
    idle_on = 1'b1;
    push_item('{1'b0, 11'sd0, 7'd0, 1'b0});
    push_item('{1'b0, -11'sd1, 7'h7F, 1'b1});
    push_item('{1'b1, -11'sd1024, 7'd127, 1'b0});
    push_item('{1'b1, 11'sd1023, 7'd0, 1'b1});
    repeat (5) push_item(random_item(1'b0));
    push_item('{1'b1, 11'sd0, 7'd50, 1'b1});
    finish_frame();
    push_item('{1'b0, 11'sd0, 7'd0, 1'b0});
    wait_for_drain();

    // A humidity frame under random ids, without idling to the end of the run.
    apply_setup(8'($urandom), 8'($urandom), 1'b1);
    idle_on = 1'b0;
    send_frame(TailTicks);
    wait_for_drain();

    if (sb.due_q.size() != 0) sb.report($sformatf("%0d results never came", sb.due_q.size()));
    if (sb.errors == 0) begin
      $display("weather_sensor_rf_frame_encoder test passed");
    end else begin
      $display("weather_sensor_rf_frame_encoder test failed");
    end
    $finish;
  end

endmodule
